/* rtl/kl_pkg.sv */
package kl_pkg;

  // Width of positions and lengths; both saturate at the all-ones value.
  localparam int POS_W = 16;

  // Number of leading word characters kept for keyword matching.
  localparam int PREFIX_DEPTH = 5;
  localparam int PREFIX_IW    = $clog2(PREFIX_DEPTH);

  // Result queue depth; a power of two so that the pointers wrap naturally.
  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);
  localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

  typedef enum logic [3:0] {
    TT_NUM    = 4'd0,
    TT_ID     = 4'd1,
    TT_VAR    = 4'd2,
    TT_MODEL  = 4'd3,
    TT_END    = 4'd4,
    TT_SOLVE  = 4'd5,
    TT_COMMA  = 4'd6,
    TT_SEMI   = 4'd7,
    TT_EQUAL  = 4'd8,
    TT_PLUS   = 4'd9,
    TT_MINUS  = 4'd10,
    TT_MUL    = 4'd11,
    TT_ERROR  = 4'd12,
    TT_FINISH = 4'd13
  } tok_type_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } scan_mode_t;

  // Input beat: a source byte or the end-of-input command.
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } kl_in_t;

  // Result beat: one token.
  typedef struct packed {
    tok_type_t        token_type;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] token_len;
    logic [7:0]       token_char;
    logic             last;
  } kl_tok_t;

  // Tokens produced by one input beat, in emission order.
  typedef struct packed {
    logic [1:0] cnt;
    kl_tok_t    tok0;
    kl_tok_t    tok1;
  } kl_push_t;

endpackage

/* rtl/kl_scan.sv */
module kl_scan
  import kl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kl_in_t   in_data,
  input  logic     q_room,
  output kl_push_t push
);

  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_EQUAL = "=";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_MUL   = "*";

  localparam logic [23:0] KW_VAR   = "var";
  localparam logic [23:0] KW_END   = "end";
  localparam logic [39:0] KW_MODEL = "model";
  localparam logic [39:0] KW_SOLVE = "solve";

  localparam logic [POS_W-1:0] POS_MAX = '1;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic tok_type_t op_type(input logic [7:0] c);
    tok_type_t t;
    unique case (c)
      CH_COMMA: t = TT_COMMA;
      CH_SEMI:  t = TT_SEMI;
      CH_EQUAL: t = TT_EQUAL;
      CH_PLUS:  t = TT_PLUS;
      CH_MINUS: t = TT_MINUS;
      CH_MUL:   t = TT_MUL;
      default:  t = TT_ERROR;
    endcase
    return t;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  // Input register.
  logic   in_v_r;
  kl_in_t in_d_r;
  logic   fire;

  assign fire     = in_v_r && q_room;
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
  end

  // Scanner state.
  scan_mode_t       mode_r, mode_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [7:0]       prefix_r [PREFIX_DEPTH];
  logic [7:0]       prefix_nxt [PREFIX_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      pos_r   <= '0;
      len_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
    end
  end

  // The prefix is only ever read at entries the current word has written.
  always_ff @(posedge clk) begin
    if (fire) begin
      prefix_r <= prefix_nxt;
    end
  end

  // Keyword match on the buffered prefix and the run length.
  tok_type_t word_tt;

  always_comb begin
    word_tt = TT_ID;
    if (len_r == POS_W'(3)) begin
      if ({prefix_r[0], prefix_r[1], prefix_r[2]} == KW_VAR) begin
        word_tt = TT_VAR;
      end else if ({prefix_r[0], prefix_r[1], prefix_r[2]} == KW_END) begin
        word_tt = TT_END;
      end
    end else if (len_r == POS_W'(5)) begin
      if ({prefix_r[0], prefix_r[1], prefix_r[2], prefix_r[3], prefix_r[4]}
          == KW_MODEL) begin
        word_tt = TT_MODEL;
      end else if ({prefix_r[0], prefix_r[1], prefix_r[2], prefix_r[3],
                    prefix_r[4]} == KW_SOLVE) begin
        word_tt = TT_SOLVE;
      end
    end
  end

  // Token formation and next state for the byte or command in the register.
  logic       has_run;
  logic       is_op;
  logic [7:0] c;
  kl_tok_t    flush_tok;
  kl_tok_t    fin_tok;
  kl_tok_t    op_tok;

  always_comb begin
    c       = in_d_r.ch;
    has_run = (mode_r != MODE_IDLE);
    is_op   = 1'b0;

    flush_tok.token_type = (mode_r == MODE_NUM) ? TT_NUM : word_tt;
    flush_tok.start_pos  = start_r;
    flush_tok.token_len  = len_r;
    flush_tok.token_char = '0;
    flush_tok.last       = 1'b0;

    fin_tok.token_type = TT_FINISH;
    fin_tok.start_pos  = pos_r;
    fin_tok.token_len  = '0;
    fin_tok.token_char = '0;
    fin_tok.last       = 1'b1;

    op_tok.token_type = op_type(c);
    op_tok.start_pos  = pos_r;
    op_tok.token_len  = POS_W'(1);
    op_tok.token_char = c;
    op_tok.last       = 1'b1;

    mode_nxt   = mode_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    push       = '0;

    if (in_d_r.cmd) begin
      // End of input: flush the pending run, then finish, and restart.
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      pos_nxt   = '0;
      len_nxt   = '0;
      if (has_run) begin
        push.cnt  = 2'd2;
        push.tok0 = flush_tok;
        push.tok1 = fin_tok;
      end else begin
        push.cnt  = 2'd1;
        push.tok0 = fin_tok;
      end
    end else begin
      pos_nxt = sat_inc(pos_r);
      if ((mode_r == MODE_NUM) && is_digit(c)) begin
        len_nxt = sat_inc(len_r);
      end else if ((mode_r == MODE_WORD) && (is_letter(c) || is_digit(c))) begin
        if (len_r < POS_W'(PREFIX_DEPTH)) begin
          prefix_nxt[len_r[PREFIX_IW-1:0]] = c;
        end
        len_nxt = sat_inc(len_r);
      end else begin
        // The byte ends any pending run and may start a new one.
        mode_nxt = MODE_IDLE;
        if (is_blank(c)) begin
          mode_nxt = MODE_IDLE;
        end else if (is_digit(c)) begin
          mode_nxt  = MODE_NUM;
          start_nxt = pos_r;
          len_nxt   = POS_W'(1);
        end else if (is_letter(c)) begin
          mode_nxt      = MODE_WORD;
          start_nxt     = pos_r;
          len_nxt       = POS_W'(1);
          prefix_nxt[0] = c;
        end else begin
          is_op = 1'b1;
        end

        if (has_run) begin
          push.tok0 = flush_tok;
          if (is_op) begin
            push.cnt  = 2'd2;
            push.tok1 = op_tok;
          end else begin
            push.cnt       = 2'd1;
            push.tok0.last = 1'b1;
          end
        end else if (is_op) begin
          push.cnt  = 2'd1;
          push.tok0 = op_tok;
        end
      end
    end

    if (!fire) begin
      push.cnt = 2'd0;
    end
  end

endmodule

/* rtl/kl_tokq.sv */
module kl_tokq
  import kl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  kl_push_t push,
  output logic     q_room,
  output logic     out_valid,
  input  logic     out_ready,
  output kl_tok_t  out_data
);

  kl_tok_t          ent_r [TQ_DEPTH];
  logic [TQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [TQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [TQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;

  // Room for the worst case of two tokens, judged on the registered count.
  assign q_room    = (cnt_r <= TQ_CW'(TQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + TQ_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + TQ_CW'(push.cnt) - TQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage; the second token of a beat goes in the following slot.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wr_ptr_r] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wr_ptr_r + 1'b1] <= push.tok1;
    end
  end

endmodule

/* rtl/keyword_lexer.sv */
// Streaming lexer: source bytes arrive one per beat on the in_ channel and
// tokens leave on the out_ channel, each with its type, start position,
// length and, for operators and errors, the byte itself. Blanks are skipped;
// digit runs give numbers, letter-led alphanumeric runs give identifiers or
// the keywords var, model, end and solve. A run is reported when the byte
// that ends it arrives, so one beat can give two tokens (the run, then an
// operator or error token); last marks the final token of each beat. An
// end-of-input beat flushes the pending run, emits finish and restarts
// positions at zero. Positions and lengths saturate at 65535. One input beat
// is taken per cycle while the queue has room. Each accepted beat is held in
// an input register, then its tokens are written into a four-entry queue,
// from which the output port drains one token per cycle while out_ready is
// high, so input stalls only while that queue has fewer than two free
// entries, that is when two-token beats or output back-pressure fill it.
module keyword_lexer
  import kl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  kl_in_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output kl_tok_t out_data
);

  kl_push_t push;
  logic     q_room;

  kl_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_room   (q_room),
    .push     (push)
  );

  kl_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_room    (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
